// File: rtl/xmlzss_pkg.sv
// ----------------------------------------------------------------------------
// xmlzss_pkg
// Shared types, constants and key table for the XOR-masked LZSS decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package xmlzss_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int HEADER_BYTES = 8;
  localparam int KEY_LENGTH   = 256;
  localparam int KEY_AW       = $clog2(KEY_LENGTH);
  localparam int LEN_W        = 5;    // copy length 2..17
  localparam int LEN_BIAS     = 2;

  // XOR key, entry 0 first
  localparam logic [0:KEY_LENGTH-1][7:0] KEY_ROM = {
    128'h8be55dc3a1e030440085c074095f5e33,
    128'hc05b8be55dc38b450c85c075148b55ec,
    128'h83c220526a00e8f528010083c4088945,
    128'h0c8b45e46a006a005053ff1534b14300,
    128'h8b451085c074058b4dec89088a45f084,
    128'hc07578a1e03044008b7de88b750c85c0,
    128'h75448b1dd0b0430085ff763781ff0000,
    128'h04006a0076438b45f88d55fc52680000,
    128'h04005650ff152cb143006a05ffd3a1e0,
    128'h30440081ef0000040081c60000040085,
    128'hc074c58b5df853e8f4fbffff8b450c83,
    128'hc4045f5e5b8be55dc38b55f88d4dfc51,
    128'h575652ff152cb14300ebd88b45e883c0,
    128'h20506a00e8472801008b7de88945f48b,
    128'hf0a1e030440083c40885c075568b1dd0,
    128'hb0430085ff764981ff000004006a0076
  };

  // token parser phase
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_HIGH  = 2'd2
  } phase_t;

  // what an accepted request leads to
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SINGLE = 2'd1,   // literal or corrupt-reference result
    ACT_COPY   = 2'd2
  } act_t;

  typedef struct packed {
    logic accept;
    logic emit_pend;
    logic rd_issue;
    logic emit_copy;
    logic clear_run;
  } cmd_t;

  typedef struct packed {
    act_t action;
    logic out_free;
    logic copy_final;
    logic cur_last;
  } status_t;

endpackage : xmlzss_pkg

`default_nettype wire

// File: rtl/xmlzss_ctrl.sv
// ----------------------------------------------------------------------------
// xmlzss_ctrl
// Sequencer: takes a request, then drives literal emission, the copy loop or neither.
// ----------------------------------------------------------------------------
`default_nettype none

module xmlzss_ctrl
  import xmlzss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIT  = 4'b0010,
    S_CRD  = 4'b0100,
    S_CWR  = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (st.action)
            ACT_SINGLE: state_next = S_LIT;
            ACT_COPY:   state_next = S_CRD;
            default:    cmd.clear_run = st.cur_last ? 1'b0 : 1'b0;
          endcase
        end
      end
      S_LIT: begin
        if (st.out_free) begin
          cmd.emit_pend = 1'b1;
          cmd.clear_run = st.cur_last;
          state_next    = S_IDLE;
        end
      end
      S_CRD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_CWR;
      end
      S_CWR: begin
        if (st.out_free) begin
          cmd.emit_copy = 1'b1;
          if (st.copy_final) begin
            cmd.clear_run = st.cur_last;
            state_next    = S_IDLE;
          end else begin
            state_next = S_CRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRD) |=> (state == S_CWR))
    else $error("copy read not followed by emit state");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_copy || cmd.emit_pend) |-> st.out_free)
    else $error("emission into an occupied output register");

  a_none_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && st.action == ACT_NONE) |=> (state == S_IDLE))
    else $error("request without results left the idle state");

endmodule : xmlzss_ctrl

`default_nettype wire

// File: rtl/xmlzss_dp.sv
// ----------------------------------------------------------------------------
// xmlzss_dp
// Datapath: unmasking, token parser, history memory, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xmlzss_dp
  import xmlzss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             corrupt,
  output logic             limit_reached,
  input  wire cmd_t        cmd,
  output status_t          st
);

  logic [31:0]       output_limit;
  logic [KEY_AW-1:0] file_offset;
  logic              header_passed;
  phase_t            token_phase;
  logic [7:0]        flag_bits;
  logic [2:0]        flag_position;
  logic [7:0]        low_count_byte;
  logic [31:0]       bytes_produced;
  logic              halted;

  logic [7:0]        pend_byte;
  logic              pend_err;
  logic              cur_last;
  logic [WIN_AW-1:0] ref_dist;
  logic [LEN_W-1:0]  remaining;

  logic [7:0]        history [WINDOW_DEPTH];
  logic [7:0]        rdata;

  logic [7:0]        d;
  logic              skip_hdr;
  logic              below_limit;
  logic [WIN_AW-1:0] dist_in;
  logic              bad_ref;
  logic              hits_limit;
  logic [2:0]        fp_inc;
  act_t              action;
  logic              out_free;

  assign d           = in_byte ^ KEY_ROM[file_offset];
  assign skip_hdr    = !header_passed && (file_offset < KEY_AW'(HEADER_BYTES));
  assign below_limit = bytes_produced < output_limit;
  assign dist_in     = {d, low_count_byte[7:4]};
  assign bad_ref     = (dist_in == '0) ||
                       ((bytes_produced[31:WIN_AW] == '0) &&
                        (dist_in > bytes_produced[WIN_AW-1:0]));
  assign hits_limit  = (bytes_produced + 32'd1) == output_limit;
  assign fp_inc      = flag_position + 3'd1;
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    action = ACT_NONE;
    if (!halted && !skip_hdr) begin
      case (token_phase)
        PH_TOKEN: if (flag_bits[flag_position] && below_limit) action = ACT_SINGLE;
        PH_HIGH:  if (below_limit) action = bad_ref ? ACT_SINGLE : ACT_COPY;
        default:  action = ACT_NONE;
      endcase
    end
  end

  assign st.action     = action;
  assign st.out_free   = out_free;
  assign st.copy_final = (remaining == LEN_W'(1)) || hits_limit;
  assign st.cur_last   = cur_last;

  // parser and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit   <= '0;
      file_offset    <= '0;
      header_passed  <= 1'b0;
      token_phase    <= PH_FLAG;
      flag_bits      <= '0;
      flag_position  <= '0;
      low_count_byte <= '0;
      bytes_produced <= '0;
      halted         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        output_limit <= cfg_wr_data;
      end
      if (cmd.accept && !halted) begin
        file_offset <= file_offset + KEY_AW'(1);
        if (!skip_hdr) begin
          header_passed <= 1'b1;
          case (token_phase)
            PH_FLAG: begin
              flag_bits     <= d;
              flag_position <= '0;
              token_phase   <= PH_TOKEN;
            end
            PH_TOKEN: begin
              if (flag_bits[flag_position]) begin
                flag_position <= fp_inc;
                token_phase   <= (fp_inc == '0) ? PH_FLAG : PH_TOKEN;
              end else begin
                low_count_byte <= d;
                token_phase    <= PH_HIGH;
              end
            end
            default: begin
              flag_position <= fp_inc;
              token_phase   <= (fp_inc == '0) ? PH_FLAG : PH_TOKEN;
              if (below_limit && bad_ref) begin
                halted <= 1'b1;
              end
            end
          endcase
        end
      end
      if ((cmd.emit_pend && !pend_err) || cmd.emit_copy) begin
        bytes_produced <= bytes_produced + 32'd1;
      end
      if (cmd.clear_run || (cmd.accept && in_last && action == ACT_NONE)) begin
        file_offset    <= '0;
        header_passed  <= 1'b0;
        token_phase    <= PH_FLAG;
        flag_bits      <= '0;
        flag_position  <= '0;
        low_count_byte <= '0;
        bytes_produced <= '0;
        halted         <= 1'b0;
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_byte <= d;
      pend_err  <= (token_phase == PH_HIGH);
      cur_last  <= in_last;
      ref_dist  <= dist_in;
      remaining <= LEN_W'(low_count_byte[3:0]) + LEN_W'(LEN_BIAS);
    end else if (cmd.emit_copy) begin
      remaining <= remaining - LEN_W'(1);
    end
  end

  // history window
  always_ff @(posedge clk) begin
    if (cmd.emit_copy) begin
      history[bytes_produced[WIN_AW-1:0]] <= rdata;
    end else if (cmd.emit_pend && !pend_err) begin
      history[bytes_produced[WIN_AW-1:0]] <= pend_byte;
    end
    if (cmd.rd_issue) begin
      rdata <= history[bytes_produced[WIN_AW-1:0] - ref_dist];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_pend || cmd.emit_copy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pend) begin
      out_byte      <= pend_err ? 8'd0 : pend_byte;
      run_last      <= 1'b1;
      corrupt       <= pend_err;
      limit_reached <= !pend_err && hits_limit;
    end else if (cmd.emit_copy) begin
      out_byte      <= rdata;
      run_last      <= st.copy_final;
      corrupt       <= 1'b0;
      limit_reached <= hits_limit;
    end
  end

endmodule : xmlzss_dp

`default_nettype wire

// File: rtl/xor_masked_lzss_decompressor.sv
// ----------------------------------------------------------------------------
// xor_masked_lzss_decompressor
// LZSS decompressor with XOR-masked input and a 4096-byte history window.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted only while idle. A literal is emitted from
//   the literal state; a copy loops history read then emit per byte (len up
//   to 17). Each emit waits for room in the output register. Header, flag and
//   low-count bytes produce nothing and leave the sequencer idle.
// Reset: synchronous, clears run state, limit and output valid; the history
//   memory is not cleared and needs no clearing pass.
`default_nettype none

module xor_masked_lzss_decompressor
  import xmlzss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: output_limit
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  // compressed byte requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // decompressed byte requests
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             corrupt,
  output logic             limit_reached
);

  // Control and data are split: the sequencer only sees a status bundle
  // (what the current request needs, output room, end of copy) and drives
  // a command bundle back into the datapath.
  cmd_t    cmd;
  status_t st;

  // Sequencer: idle -> (literal emit | copy read/emit loop) -> idle.
  // A request that produces nothing returns to idle in the same cycle,
  // so header and flag bytes stream at one per clock.
  xmlzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: key unmasking by file offset, flag/token parser, distance
  // check, history window (one write or one read a cycle) and the output
  // register that decouples the two channels.
  xmlzss_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .corrupt       (corrupt),
    .limit_reached (limit_reached),
    .cmd           (cmd),
    .st            (st)
  );

endmodule : xor_masked_lzss_decompressor

`default_nettype wire

// File: test/xor_masked_lzss_decompressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_masked_lzss_decompressor_tb
// Self-checking bench for the XOR-masked LZSS decompressor. A queue of coded
// bytes feeds a clocked driver; each accepted request runs through a local
// decoder that queues the bytes the block should produce, and a clocked
// monitor compares every output request against them field by field.
// ----------------------------------------------------------------------------

module xor_masked_lzss_decompressor_tb;
  import xmlzss_pkg::*;

  localparam int HDR_LEN = 8;
  localparam int WIN     = 4096;

  // mask table, entry 0 first
  localparam logic [0:255][7:0] XOR_KEY = {
    128'h8be55dc3a1e030440085c074095f5e33,
    128'hc05b8be55dc38b450c85c075148b55ec,
    128'h83c220526a00e8f528010083c4088945,
    128'h0c8b45e46a006a005053ff1534b14300,
    128'h8b451085c074058b4dec89088a45f084,
    128'hc07578a1e03044008b7de88b750c85c0,
    128'h75448b1dd0b0430085ff763781ff0000,
    128'h04006a0076438b45f88d55fc52680000,
    128'h04005650ff152cb143006a05ffd3a1e0,
    128'h30440081ef0000040081c60000040085,
    128'hc074c58b5df853e8f4fbffff8b450c83,
    128'hc4045f5e5b8be55dc38b55f88d4dfc51,
    128'h575652ff152cb14300ebd88b45e883c0,
    128'h20506a00e8472801008b7de88945f48b,
    128'hf0a1e030440083c40885c075568b1dd0,
    128'hb0430085ff764981ff000004006a0076
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       corrupt;
    logic       lim_hit;
  } plain_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte     = 8'h00;
  logic        in_last     = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        corrupt;
  logic        limit_reached;

  xor_masked_lzss_decompressor dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .corrupt       (corrupt),
    .limit_reached (limit_reached)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  coded_t coded_q[$];   // coded bytes waiting to be offered
  plain_t plain_q[$];   // decoded bytes still owed by the block
  plain_t fresh_q[$];   // bytes from the request being decoded
  int     bad_cnt  = 0;
  int     sent_cnt = 0;
  int     got_cnt  = 0;

  // --------------------------------------------------------------------------
  // Decoder state, mirrors the block
  // --------------------------------------------------------------------------
  logic [31:0] lim_q    = 32'h0;
  logic [7:0]  ofs_q    = 8'h00;
  logic        hdr_done = 1'b0;
  phase_t      ph_q     = PH_FLAG;
  logic [7:0]  flags_q  = 8'h00;
  logic [2:0]  fpos_q   = 3'd0;
  logic [7:0]  lowc_q   = 8'h00;
  logic [31:0] made_q   = 32'h0;
  logic        halt_q   = 1'b0;
  logic [7:0]  hist_q [WIN];

  task automatic emit_plain(input logic [7:0] b);
    hist_q[made_q[11:0]] = b;
    made_q++;
    fresh_q.push_back('{data: b, run_last: 1'b0, corrupt: 1'b0, lim_hit: made_q == lim_q});
  endtask

  task automatic next_slot();
    fpos_q = fpos_q + 3'd1;
    ph_q   = (fpos_q == 3'd0) ? PH_FLAG : PH_TOKEN;
  endtask

  // Works out what one accepted coded byte should produce
  task automatic decode_byte(input logic [7:0] raw, input logic fin);
    logic [7:0]  d;
    logic [15:0] code;
    logic [11:0] reach_back;
    logic [4:0]  len;
    logic [31:0] room;
    logic [31:0] src;
    fresh_q.delete();
    if (!halt_q) begin
      if (!hdr_done && ofs_q < HDR_LEN) begin
        ofs_q++;                              // header byte, dropped
      end else begin
        d        = raw ^ XOR_KEY[ofs_q];
        hdr_done = 1'b1;
        ofs_q++;
        case (ph_q)
          PH_FLAG: begin
            flags_q = d;
            fpos_q  = 3'd0;
            ph_q    = PH_TOKEN;
          end
          PH_TOKEN: begin
            if (flags_q[fpos_q]) begin
              if (made_q < lim_q) emit_plain(d);
              next_slot();
            end else begin
              lowc_q = d;
              ph_q   = PH_HIGH;
            end
          end
          default: begin
            code       = {d, lowc_q};
            reach_back = code[15:4];
            len        = 5'(code[3:0]) + 5'd2;
            // past the limit the token is swallowed without a distance check
            if (made_q < lim_q) begin
              if (reach_back == 12'd0 || 32'(reach_back) > made_q) begin
                fresh_q.push_back('{data: 8'h00, run_last: 1'b0, corrupt: 1'b1,
                                   lim_hit: 1'b0});
                halt_q = 1'b1;
              end else begin
                room = lim_q - made_q;
                if (32'(len) > room) len = room[4:0];
                for (int i = 0; i < int'(len); i++) begin
                  src = made_q - 32'(reach_back);
                  emit_plain(hist_q[src[11:0]]);   // may read a byte just written
                end
              end
            end
            next_slot();
          end
        endcase
      end
    end
    if (fresh_q.size() != 0) fresh_q[fresh_q.size()-1].run_last = 1'b1;
    foreach (fresh_q[i]) plain_q.push_back(fresh_q[i]);
    if (fin) begin
      ofs_q    = 8'h00;
      hdr_done = 1'b0;
      ph_q     = PH_FLAG;
      flags_q  = 8'h00;
      fpos_q   = 3'd0;
      lowc_q   = 8'h00;
      made_q   = 32'h0;
      halt_q   = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers coded bytes, random gaps outside a quiet stretch
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    coded_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, in_last);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (coded_q.size() != 0 &&
            !($urandom_range(99) < 11 && !(sent_cnt >= 50 && sent_cnt < 110))) begin
          nxt = coded_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.data;
          in_last  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off so the block backs up
  // --------------------------------------------------------------------------
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left = 300;
      hold_done = 1'b1;
    end else begin
      out_ready <= (got_cnt >= 60 && got_cnt < 160) || $urandom_range(99) >= 11;
    end
  end

  task automatic log_fault(input string what, input plain_t want, input plain_t seen);
    bad_cnt++;
    if (bad_cnt <= 10) begin
      $write("%0t %s: exp byte %02h last %0b corrupt %0b limit %0b",
             $time, what, want.data, want.run_last, want.corrupt, want.lim_hit);
      $display(" / got byte %02h last %0b corrupt %0b limit %0b",
               seen.data, seen.run_last, seen.corrupt, seen.lim_hit);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: every output request against the oldest owed byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    plain_t want;
    plain_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{data: out_byte, run_last: run_last, corrupt: corrupt, lim_hit: limit_reached};
      got_cnt++;
      if (plain_q.size() == 0) begin
        log_fault("unexpected result", '0, seen);
      end else begin
        want = plain_q.pop_front();
        if (seen !== want) log_fault("result mismatch", want, seen);
      end
    end
  end

  // --------------------------------------------------------------------------
  // File builder: masks plain bytes by file offset, tracks output so that
  // generated distances stay in range
  // --------------------------------------------------------------------------
  logic [7:0] gen_pos  = 8'h00;
  longint     gen_made = 0;
  longint     gen_lim  = 0;

  task automatic send_raw(input logic [7:0] b);
    coded_q.push_back('{data: b, last: 1'b0});
    gen_pos++;
  endtask

  task automatic send_plain(input logic [7:0] d);
    send_raw(d ^ XOR_KEY[gen_pos]);
  endtask

  task automatic send_ref(input int reach, input int len);
    logic [15:0] code;
    code = {12'(reach), 4'(len - 2)};
    send_plain(code[7:0]);
    send_plain(code[15:8]);
  endtask

  task automatic gen_bump(input int n);
    if (gen_made < gen_lim) gen_made = (gen_lim - gen_made < n) ? gen_lim : gen_made + n;
  endtask

  task automatic start_file();
    repeat (HDR_LEN) send_raw(8'($urandom));
  endtask

  task automatic end_file();
    coded_q[coded_q.size()-1].last = 1'b1;
    gen_pos  = 8'h00;
    gen_made = 0;
  endtask

  // one flag byte and its eight tokens; bad_pct injects invalid distances
  task automatic gen_group(input int lit_pct, input int bad_pct);
    logic [7:0] flags;
    logic [7:0] lit [8];
    int         reach [8];
    int         len [8];
    int         top;
    flags = 8'h00;
    for (int t = 0; t < 8; t++) begin
      top = (gen_made > 4095) ? 4095 : int'(gen_made);
      if ((gen_made == 0 && gen_lim != 0) || $urandom_range(99) < lit_pct) begin
        flags[t] = 1'b1;
        lit[t]   = 8'($urandom);
        gen_bump(1);
      end else begin
        len[t] = $urandom_range(2, 17);
        if (gen_made >= gen_lim) begin
          reach[t] = $urandom_range(0, 4095);   // never checked
        end else if ($urandom_range(99) < bad_pct) begin
          case ($urandom_range(2))
            0:       reach[t] = 0;
            1:       reach[t] = 4095;
            default: reach[t] = (top >= 4095) ? 0 : top + 1;
          endcase
        end else begin
          case ($urandom_range(3))
            0:       reach[t] = 1;
            1:       reach[t] = $urandom_range(1, (top < 4) ? top : 4);
            2:       reach[t] = top;
            default: reach[t] = $urandom_range(1, top);
          endcase
        end
        gen_bump(len[t]);
      end
    end
    send_plain(flags);
    for (int t = 0; t < 8; t++) begin
      if (flags[t]) send_plain(lit[t]);
      else send_ref(reach[t], len[t]);
    end
  endtask

  task automatic set_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lim_q   = v;
    gen_lim = v;
    @(negedge clk);
  endtask

  // hold the sender until the block owes nothing, then let it settle
  task automatic wait_drained(input int settle);
    do @(negedge clk); while (coded_q.size() != 0 || in_valid || plain_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    int          base;
    int          kind;
    int          file_head;
    int          cut;
    logic [31:0] lim_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed file: field extremes, literals, overlapping and shortest
    // copies, a distance one beyond the bytes produced that halts the run
    // until its last byte, then a zero distance
    set_limit(32'hFFFF_FFFF);
    send_raw(8'h00); send_raw(8'hFF); send_raw(8'h55); send_raw(8'hAA);
    send_raw(8'h0F); send_raw(8'hF0); send_raw(8'h80); send_raw(8'h01);
    send_plain(8'h93);
    send_plain(8'h00);
    send_plain(8'hFF);
    send_ref(1, 17);
    send_ref(2, 2);
    send_plain(8'h5A);
    send_ref(23, 3);
    send_ref(0, 5);
    send_raw(8'hC3);
    end_file();
    wait_drained(40);

    // limit of zero: every token is parsed and swallowed
    set_limit(32'h0);
    start_file();
    gen_group(30, 0);
    end_file();
    wait_drained(40);

    // small limit clamps a copy, then a raised limit resumes the same run
    lim_pick = $urandom_range(10, 30);
    set_limit(lim_pick);
    start_file();
    repeat (2) gen_group(40, 0);
    wait_drained(40);
    set_limit(lim_pick + $urandom_range(20, 60));
    gen_group(40, 0);
    end_file();
    wait_drained(40);

    // random files: mostly well formed, some corrupt, truncated or noise
    set_limit(32'hFFFF_FFFF);
    hold_req = 1'b1;
    base = sent_cnt + coded_q.size();
    while (sent_cnt + coded_q.size() - base < 75) begin
      if (sent_cnt + coded_q.size() != base && $urandom_range(3) == 0) begin
        wait_drained(40);
        case ($urandom_range(3))
          0:       lim_pick = 32'hFFFF_FFFF;
          1:       lim_pick = $urandom_range(1, 120);
          2:       lim_pick = $urandom;
          default: lim_pick = 32'h0;
        endcase
        set_limit(lim_pick);
      end
      kind      = $urandom_range(99);
      file_head = coded_q.size();
      start_file();
      if (kind < 10) begin
        repeat ($urandom_range(4, 24)) send_raw(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) gen_group(35, (kind < 25) ? 15 : 0);
        if (kind >= 85) begin
          // cut the file short, possibly inside a token
          cut = $urandom_range(file_head, coded_q.size() - 1);
          while (coded_q.size() > cut + 1) void'(coded_q.pop_back());
        end
      end
      end_file();
    end

    wait_drained(60);
    if (bad_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/xmlzss_pkg.sv
rtl/xmlzss_ctrl.sv
rtl/xmlzss_dp.sv
rtl/xor_masked_lzss_decompressor.sv
test/xor_masked_lzss_decompressor_tb.sv
